/* hw/rtl/whp_pkg.sv */
// Shared types and constants of the WAV header parser.
package whp_pkg;

	localparam int unsigned POS_W = 5;

	// parse phase, one-hot
	typedef enum logic [4:0] {
		PH_RIFF    = 5'b00001,
		PH_FMT     = 5'b00010,
		PH_DATATAG = 5'b00100,
		PH_PAYLOAD = 5'b01000,
		PH_IDLE    = 5'b10000
	} phase_t;

	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	localparam logic ERR_NOT_WAV = 1'b0;
	localparam logic ERR_INVALID = 1'b1;

	localparam logic [2:0] FMT_MONO8       = 3'd0;
	localparam logic [2:0] FMT_MONO16      = 3'd1;
	localparam logic [2:0] FMT_STEREO8     = 3'd2;
	localparam logic [2:0] FMT_STEREO16    = 3'd3;
	localparam logic [2:0] FMT_UNSUPPORTED = 3'd4;

	// tags, first character in the low byte
	localparam logic [31:0] TAG_RIFF = 32'h46464952;
	localparam logic [31:0] TAG_WAVE = 32'h45564157;
	localparam logic [31:0] TAG_FMT  = 32'h20746D66;
	localparam logic [31:0] TAG_DATA = 32'h61746164;

	localparam logic [31:0] FMT_BASE_SIZE = 32'd16;
	localparam logic [15:0] BITS_8        = 16'd8;

	function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
		tag_byte = tag[{idx, 3'b000} +: 8];
	endfunction

	function automatic logic [2:0] format_of(input logic [15:0] chans, input logic [15:0] bits);
		logic is8;
		is8 = (bits == BITS_8);
		if (chans == 16'd1) begin
			format_of = is8 ? FMT_MONO8 : FMT_MONO16;
		end else if (chans == 16'd2) begin
			format_of = is8 ? FMT_STEREO8 : FMT_STEREO16;
		end else begin
			format_of = FMT_UNSUPPORTED;
		end
	endfunction

endpackage

/* hw/rtl/wav_header_parser.sv */
// WAV (RIFF) header parser: tag checks, header fields, payload pass-through.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------------------
//  in      | input     | in_valid / in_ready | data_byte, start_of_file
//  out     | output    | out_valid/out_ready | result_kind, format_code, sample_rate,
//          |           |                     | byte_rate, data_size, payload_byte,
//          |           |                     | last_payload, error_code
//
// One byte per cycle sustained while the result side is not stalled. A byte is held in
// the input register and parsed by the phase logic; any result lands in the result register.
// Reset clears the phase to the RIFF tag, so a file may start without start_of_file.
// A stalled result register stalls the parse stage; the input register still takes
// one more byte while the stage is free.
module wav_header_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        start_of_file,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic [2:0]  format_code,
	output logic [31:0] sample_rate,
	output logic [31:0] byte_rate,
	output logic [31:0] data_size,
	output logic [7:0]  payload_byte,
	output logic        last_payload,
	output logic        error_code
);

	// input stage
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        sof_s1;

	// parse state
	whp_pkg::phase_t              phase_q;
	logic [whp_pkg::POS_W-1:0]    pos_q;
	logic [31:0]                  shift_q;
	logic                         ext_q;
	logic [15:0]                  chan_q;
	logic [15:0]                  bits_q;
	logic [31:0]                  rate_smp_q;
	logic [31:0]                  rate_byt_q;
	logic [31:0]                  remain_q;

	// result register
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [2:0]  fmt_q;
	logic [31:0] srate_q;
	logic [31:0] brate_q;
	logic [31:0] dsize_q;
	logic [7:0]  pbyte_q;
	logic        last_q;
	logic        err_q;

	logic proceed;
	logic fire;

	assign proceed  = !out_valid_q || out_ready;
	assign fire     = valid_s1 && proceed;
	assign in_ready = !valid_s1 || proceed;

	// next-state and result logic
	whp_pkg::phase_t           phase_e;
	whp_pkg::phase_t           phase_n;
	logic [whp_pkg::POS_W-1:0] pos_e;
	logic [whp_pkg::POS_W-1:0] pos_n;
	logic [whp_pkg::POS_W-1:0] pos_inc;
	logic [31:0]               shift_n;
	logic                      ext_n;
	logic [15:0]               chan_n;
	logic [15:0]               bits_n;
	logic [31:0]               rate_smp_n;
	logic [31:0]               rate_byt_n;
	logic [31:0]               remain_n;
	logic [31:0]               remain_dec;
	logic                      res_v;
	logic [1:0]                res_kind;
	logic [2:0]                res_fmt;
	logic [31:0]               res_srate;
	logic [31:0]               res_brate;
	logic [31:0]               res_dsize;
	logic [7:0]                res_pbyte;
	logic                      res_last;
	logic                      res_err;

	always_comb begin
		phase_e    = sof_s1 ? whp_pkg::PH_RIFF : phase_q;
		pos_e      = sof_s1 ? '0 : pos_q;
		pos_inc    = pos_e + 1'b1;
		shift_n    = {byte_s1, shift_q[31:8]};
		remain_dec = remain_q - 32'd1;

		phase_n    = phase_e;
		pos_n      = pos_e;
		ext_n      = ext_q;
		chan_n     = chan_q;
		bits_n     = bits_q;
		rate_smp_n = rate_smp_q;
		rate_byt_n = rate_byt_q;
		remain_n   = remain_q;

		res_v      = 1'b0;
		res_kind   = whp_pkg::KIND_HEADER;
		res_fmt    = '0;
		res_srate  = '0;
		res_brate  = '0;
		res_dsize  = '0;
		res_pbyte  = '0;
		res_last   = 1'b0;
		res_err    = whp_pkg::ERR_NOT_WAV;

		case (phase_e)
			whp_pkg::PH_RIFF: begin
				if ((pos_e < 5'd4 &&
				     byte_s1 != whp_pkg::tag_byte(whp_pkg::TAG_RIFF, pos_e[1:0])) ||
				    (pos_e >= 5'd8 && pos_e < 5'd12 &&
				     byte_s1 != whp_pkg::tag_byte(whp_pkg::TAG_WAVE, pos_e[1:0]))) begin
					res_v    = 1'b1;
					res_kind = whp_pkg::KIND_ERROR;
					res_err  = whp_pkg::ERR_NOT_WAV;
					phase_n  = whp_pkg::PH_IDLE;
				end else if (pos_e >= 5'd11) begin
					phase_n = whp_pkg::PH_FMT;
					pos_n   = '0;
				end else begin
					pos_n = pos_inc;
				end
			end
			whp_pkg::PH_FMT: begin
				if (pos_e < 5'd4 &&
				    byte_s1 != whp_pkg::tag_byte(whp_pkg::TAG_FMT, pos_e[1:0])) begin
					res_v    = 1'b1;
					res_kind = whp_pkg::KIND_ERROR;
					res_err  = whp_pkg::ERR_INVALID;
					phase_n  = whp_pkg::PH_IDLE;
				end else begin
					if (pos_e == 5'd7)  ext_n      = (shift_n > whp_pkg::FMT_BASE_SIZE);
					if (pos_e == 5'd11) chan_n     = shift_n[31:16];
					if (pos_e == 5'd15) rate_smp_n = shift_n;
					if (pos_e == 5'd19) rate_byt_n = shift_n;
					if (pos_e == 5'd23) bits_n     = shift_n[31:16];
					// two extension bytes follow bits-per-sample when fmt size > 16
					if ((pos_e == 5'd23 && !ext_q) || pos_e >= 5'd25) begin
						phase_n = whp_pkg::PH_DATATAG;
						pos_n   = '0;
					end else begin
						pos_n = pos_inc;
					end
				end
			end
			whp_pkg::PH_DATATAG: begin
				if (pos_e < 5'd4 &&
				    byte_s1 != whp_pkg::tag_byte(whp_pkg::TAG_DATA, pos_e[1:0])) begin
					res_v    = 1'b1;
					res_kind = whp_pkg::KIND_ERROR;
					res_err  = whp_pkg::ERR_INVALID;
					phase_n  = whp_pkg::PH_IDLE;
				end else if (pos_e >= 5'd7) begin
					remain_n  = shift_n;
					pos_n     = '0;
					phase_n   = (shift_n != 32'd0) ? whp_pkg::PH_PAYLOAD : whp_pkg::PH_IDLE;
					res_v     = 1'b1;
					res_kind  = whp_pkg::KIND_HEADER;
					res_fmt   = whp_pkg::format_of(chan_q, bits_q);
					res_srate = rate_smp_q;
					res_brate = rate_byt_q;
					res_dsize = shift_n;
				end else begin
					pos_n = pos_inc;
				end
			end
			whp_pkg::PH_PAYLOAD: begin
				remain_n  = remain_dec;
				res_v     = 1'b1;
				res_kind  = whp_pkg::KIND_PAYLOAD;
				res_pbyte = byte_s1;
				res_last  = (remain_dec == 32'd0);
				if (remain_dec == 32'd0) phase_n = whp_pkg::PH_IDLE;
			end
			default: begin
				// idle: bytes are dropped until the next start of file
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q     <= whp_pkg::PH_RIFF;
			pos_q       <= '0;
			ext_q       <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (proceed) begin
				out_valid_q <= valid_s1 && res_v;
			end
			if (fire) begin
				phase_q <= phase_n;
				pos_q   <= pos_n;
				ext_q   <= ext_n;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			sof_s1  <= start_of_file;
		end
		if (fire) begin
			shift_q    <= shift_n;
			chan_q     <= chan_n;
			bits_q     <= bits_n;
			rate_smp_q <= rate_smp_n;
			rate_byt_q <= rate_byt_n;
			remain_q   <= remain_n;
		end
		if (fire && res_v) begin
			kind_q  <= res_kind;
			fmt_q   <= res_fmt;
			srate_q <= res_srate;
			brate_q <= res_brate;
			dsize_q <= res_dsize;
			pbyte_q <= res_pbyte;
			last_q  <= res_last;
			err_q   <= res_err;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = kind_q;
	assign format_code  = fmt_q;
	assign sample_rate  = srate_q;
	assign byte_rate    = brate_q;
	assign data_size    = dsize_q;
	assign payload_byte = pbyte_q;
	assign last_payload = last_q;
	assign error_code   = err_q;

endmodule

/* hw/rtl/whp_checker.sv */
// Port-level checks for the WAV header parser, bound to the top level.
module whp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  result_kind,
	input logic [2:0]  format_code,
	input logic [31:0] sample_rate,
	input logic [31:0] data_size,
	input logic [7:0]  payload_byte,
	input logic        last_payload,
	input logic        error_code
);

	// a stalled result transaction holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_kind) &&
		$stable(payload_byte) && $stable(data_size))
		else $error("result changed while stalled");

	// with the result register empty the parse stage is free, so input is taken
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == whp_pkg::KIND_PAYLOAD |->
		error_code == 1'b0 && format_code == 3'd0 && data_size == 32'd0)
		else $error("payload result carries header or error fields");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == whp_pkg::KIND_ERROR |->
		last_payload == 1'b0 && payload_byte == 8'd0 && sample_rate == 32'd0)
		else $error("error result carries payload fields");

	a_header_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == whp_pkg::KIND_HEADER |->
		last_payload == 1'b0 && error_code == 1'b0 && payload_byte == 8'd0)
		else $error("header result carries payload or error fields");

endmodule

bind wav_header_parser whp_checker u_whp_checker (.*);

/* tb/tb_wav_header_parser.sv */
// Self-checking testbench for wav_header_parser: directed table plus random WAV streams.
module tb_wav_header_parser;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RAND_ITEMS = 425;
	localparam int unsigned DIR_ROWS   = 23;
	localparam int unsigned MAX_SHOWN  = 10;

	localparam logic [31:0] RIFF_S = "RIFF";
	localparam logic [31:0] WAVE_S = "WAVE";
	localparam logic [31:0] FMT_S  = "fmt ";
	localparam logic [31:0] DATA_S = "data";

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  fmt;
		logic [31:0] srate;
		logic [31:0] brate;
		logic [31:0] dsize;
		logic [7:0]  pbyte;
		logic        last;
		logic        err;
	} wav_result_t;

	// how a directed row is checked
	typedef enum logic [1:0] {
		BY_PARSER,
		NO_RESULT,
		TAG_ERROR
	} row_chk_t;

	typedef struct packed {
		logic [7:0] b;
		logic       sof;
		row_chk_t   chk;
		logic       code;
	} dir_row_t;

	localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
		'{"Q",   1'b0, TAG_ERROR, whp_pkg::ERR_NOT_WAV},	// no start mark right after reset
		'{"R",   1'b0, NO_RESULT, 1'b0},	// idle: ignored
		'{"R",   1'b1, BY_PARSER, 1'b0},
		'{"I",   1'b0, BY_PARSER, 1'b0},
		'{"F",   1'b0, BY_PARSER, 1'b0},
		'{"F",   1'b0, BY_PARSER, 1'b0},
		'{8'hFF, 1'b0, BY_PARSER, 1'b0},
		'{8'h00, 1'b0, BY_PARSER, 1'b0},
		'{8'hFF, 1'b0, BY_PARSER, 1'b0},
		'{8'h00, 1'b0, BY_PARSER, 1'b0},
		'{"W",   1'b0, BY_PARSER, 1'b0},
		'{"A",   1'b0, BY_PARSER, 1'b0},
		'{"V",   1'b0, BY_PARSER, 1'b0},
		'{"E",   1'b0, BY_PARSER, 1'b0},
		'{"f",   1'b0, BY_PARSER, 1'b0},
		'{"m",   1'b0, BY_PARSER, 1'b0},
		'{"x",   1'b0, TAG_ERROR, whp_pkg::ERR_INVALID},
		'{"R",   1'b1, BY_PARSER, 1'b0},
		'{"I",   1'b0, BY_PARSER, 1'b0},
		'{"R",   1'b1, BY_PARSER, 1'b0},	// restart in the middle of a file
		'{"I",   1'b0, BY_PARSER, 1'b0},
		'{"G",   1'b0, TAG_ERROR, whp_pkg::ERR_NOT_WAV},
		'{8'h00, 1'b1, TAG_ERROR, whp_pkg::ERR_NOT_WAV}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        start_of_file = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  result_kind;
	logic [2:0]  format_code;
	logic [31:0] sample_rate;
	logic [31:0] byte_rate;
	logic [31:0] data_size;
	logic [7:0]  payload_byte;
	logic        last_payload;
	logic        error_code;

	wav_header_parser DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.start_of_file(start_of_file),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_kind  (result_kind),
		.format_code  (format_code),
		.sample_rate  (sample_rate),
		.byte_rate    (byte_rate),
		.data_size    (data_size),
		.payload_byte (payload_byte),
		.last_payload (last_payload),
		.error_code   (error_code)
	);

	always #2 clk = ~clk;

	// parser state mirror
	whp_pkg::phase_t ph = whp_pkg::PH_RIFF;
	logic [5:0]  pos = '0;
	logic [31:0] shift_reg = '0;
	logic        ext = 1'b0;
	logic [15:0] chans = '0;
	logic [15:0] sample_depth = '0;
	logic [31:0] srate = '0;
	logic [31:0] brate = '0;
	logic [31:0] remaining = '0;

	wav_result_t due_results[$];
	logic [7:0]  file_bytes[$];

	int unsigned fail_count = 0;
	int unsigned byte_count = 0;
	int unsigned parsed_count = 0;
	int unsigned hdr_seen = 0;
	int unsigned pay_seen = 0;
	int unsigned err_seen = 0;
	int unsigned in_burst = 0;
	int unsigned out_burst = 0;

	function automatic logic [7:0] tag_char(input logic [31:0] t, input int unsigned idx);
		return t[8 * (3 - idx) +: 8];
	endfunction

	function automatic void clear_parse();
		ph = whp_pkg::PH_RIFF;
		pos = '0;
		shift_reg = '0;
		ext = 1'b0;
		chans = '0;
		sample_depth = '0;
		srate = '0;
		brate = '0;
		remaining = '0;
	endfunction

	function automatic bit tag_fail(output wav_result_t r, input logic code);
		r = '0;
		r.kind = whp_pkg::KIND_ERROR;
		r.err = code;
		ph = whp_pkg::PH_IDLE;
		return 1'b1;
	endfunction

	// advances the mirror by one byte; returns 1 with the result when the byte causes one
	function automatic bit parse_byte(input logic [7:0] b, input logic sof,
			output wav_result_t r);
		r = '0;
		if (sof)
			clear_parse();
		shift_reg = {b, shift_reg[31:8]};
		case (ph)
			whp_pkg::PH_RIFF: begin
				if (pos < 4 && b != tag_char(RIFF_S, pos))
					return tag_fail(r, whp_pkg::ERR_NOT_WAV);
				if (pos >= 8 && pos < 12 && b != tag_char(WAVE_S, pos - 8))
					return tag_fail(r, whp_pkg::ERR_NOT_WAV);
				if (pos >= 11) begin
					ph = whp_pkg::PH_FMT;
					pos = '0;
				end else begin
					pos = pos + 1'b1;
				end
				return 1'b0;
			end
			whp_pkg::PH_FMT: begin
				if (pos < 4 && b != tag_char(FMT_S, pos))
					return tag_fail(r, whp_pkg::ERR_INVALID);
				case (pos)
					6'd7:  ext = shift_reg > 32'd16;
					6'd11: chans = shift_reg[31:16];
					6'd15: srate = shift_reg;
					6'd19: brate = shift_reg;
					6'd23: sample_depth = shift_reg[31:16];
					default: ;
				endcase
				// the 2 extension bytes sit after bits-per-sample
				if ((pos == 6'd23 && !ext) || pos >= 6'd25) begin
					ph = whp_pkg::PH_DATATAG;
					pos = '0;
				end else begin
					pos = pos + 1'b1;
				end
				return 1'b0;
			end
			whp_pkg::PH_DATATAG: begin
				if (pos < 4 && b != tag_char(DATA_S, pos))
					return tag_fail(r, whp_pkg::ERR_INVALID);
				if (pos >= 7) begin
					remaining = shift_reg;
					pos = '0;
					ph = (shift_reg != 0) ? whp_pkg::PH_PAYLOAD : whp_pkg::PH_IDLE;
					r.kind = whp_pkg::KIND_HEADER;
					if (chans == 16'd1)
						r.fmt = (sample_depth == 16'd8) ? whp_pkg::FMT_MONO8 :
							whp_pkg::FMT_MONO16;
					else if (chans == 16'd2)
						r.fmt = (sample_depth == 16'd8) ? whp_pkg::FMT_STEREO8 :
							whp_pkg::FMT_STEREO16;
					else
						r.fmt = whp_pkg::FMT_UNSUPPORTED;
					r.srate = srate;
					r.brate = brate;
					r.dsize = shift_reg;
					return 1'b1;
				end
				pos = pos + 1'b1;
				return 1'b0;
			end
			whp_pkg::PH_PAYLOAD: begin
				remaining = remaining - 1;
				r.kind = whp_pkg::KIND_PAYLOAD;
				r.pbyte = b;
				r.last = (remaining == 0);
				if (remaining == 0)
					ph = whp_pkg::PH_IDLE;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// wait cycles before the next transaction, with occasional back-to-back stretches
	function automatic int unsigned draw_gap(inout int unsigned burst);
		if (burst != 0) begin
			burst = burst - 1;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			burst = $urandom_range(20, 60);
			return 0;
		end
		return $urandom_range(0, 7);
	endfunction

	function automatic string res_str(input wav_result_t r);
		return $sformatf("kind=%0d fmt=%0d rate=%h brate=%h size=%h byte=%h last=%b err=%b",
			r.kind, r.fmt, r.srate, r.brate, r.dsize, r.pbyte, r.last, r.err);
	endfunction

	function automatic void report(input string what, input wav_result_t want,
			input wav_result_t got);
		fail_count++;
		if (fail_count <= MAX_SHOWN) begin
			$display("[%0t] %s", $realtime, what);
			$display("    expected: %s", res_str(want));
			$display("    actual:   %s", res_str(got));
		end
	endfunction

	task automatic drive_item(input logic [7:0] b, input logic sof, input row_chk_t chk,
			input logic code);
		int unsigned gap;
		wav_result_t r;
		bit got;
		gap = draw_gap(in_burst);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		start_of_file <= sof;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		byte_count++;
		if (sof || ph != whp_pkg::PH_IDLE)
			parsed_count++;
		got = parse_byte(b, sof, r);
		case (chk)
			BY_PARSER: begin
				if (got)
					due_results.push_back(r);
			end
			TAG_ERROR: begin
				r = '0;
				r.kind = whp_pkg::KIND_ERROR;
				r.err = code;
				due_results.push_back(r);
			end
			default: ;
		endcase
	endtask

	task automatic push_le(input logic [31:0] v, input int unsigned n);
		for (int unsigned k = 0; k < n; k++)
			file_bytes.push_back(v[8 * k +: 8]);
	endtask

	task automatic push_tag(input logic [31:0] t);
		for (int unsigned k = 0; k < 4; k++)
			file_bytes.push_back(tag_char(t, k));
	endtask

	function automatic logic [31:0] wide_val();
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// one WAV stream, mostly well formed; some get a bad tag, a cut, or turn into noise
	task automatic send_file();
		logic [31:0] fmt_size;
		logic [31:0] dsize;
		int unsigned flaw;
		int unsigned cut;
		int unsigned tag_at;
		int unsigned n;
		int unsigned dtag;
		logic first_sof;
		file_bytes.delete();
		push_tag(RIFF_S);
		push_le(wide_val(), 4);
		push_tag(WAVE_S);
		push_tag(FMT_S);
		case ($urandom_range(0, 7))
			0, 1, 2, 3: fmt_size = 32'd16;
			4: fmt_size = 32'd18;
			5: fmt_size = 32'd17;
			6: fmt_size = $urandom_range(0, 16);
			default: fmt_size = $urandom;
		endcase
		push_le(fmt_size, 4);
		push_le($urandom, 2);
		case ($urandom_range(0, 7))
			0, 1, 2: push_le(32'd1, 2);
			3, 4, 5: push_le(32'd2, 2);
			6: push_le(32'd0, 2);
			default: push_le($urandom, 2);
		endcase
		push_le(wide_val(), 4);
		push_le(wide_val(), 4);
		push_le($urandom, 2);
		case ($urandom_range(0, 3))
			0, 1: push_le(32'd8, 2);
			2: push_le(32'd16, 2);
			default: push_le($urandom, 2);
		endcase
		if (fmt_size > 32'd16)
			push_le($urandom, 2);
		dtag = file_bytes.size();
		push_tag(DATA_S);
		case ($urandom_range(0, 7))
			0: dsize = 32'd0;
			1: dsize = wide_val();
			default: dsize = $urandom_range(1, 12);
		endcase
		push_le(dsize, 4);
		// huge sizes are cut short by the next start of file
		n = (dsize > 12) ? $urandom_range(1, 12) : dsize;
		repeat (n) push_le($urandom, 1);

		first_sof = 1'b1;
		flaw = $urandom_range(0, 9);
		if (flaw == 7) begin
			case ($urandom_range(0, 3))
				0: tag_at = $urandom_range(0, 3);
				1: tag_at = $urandom_range(8, 11);
				2: tag_at = $urandom_range(12, 15);
				default: tag_at = dtag + $urandom_range(0, 3);
			endcase
			file_bytes[tag_at] = file_bytes[tag_at] ^ 8'($urandom_range(1, 255));
			cut = tag_at + 1;
		end else if (flaw == 8) begin
			cut = $urandom_range(1, file_bytes.size() - 1);
		end else if (flaw == 9) begin
			file_bytes.delete();
			repeat ($urandom_range(1, 8)) push_le($urandom, 1);
			cut = file_bytes.size();
			first_sof = 1'($urandom_range(0, 1));
		end else begin
			cut = file_bytes.size();
		end

		for (int unsigned i = 0; i < cut; i++)
			drive_item(file_bytes[i], (i == 0) ? first_sof : 1'b0, BY_PARSER, 1'b0);
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) drive_item(8'($urandom), 1'b0, BY_PARSER, 1'b0);
	endtask

	// result side: random stalls, every transaction checked against the oldest expectation
	initial begin
		int unsigned stall;
		wav_result_t got;
		wav_result_t want;
		forever begin
			stall = draw_gap(out_burst);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			got.kind = result_kind;
			got.fmt = format_code;
			got.srate = sample_rate;
			got.brate = byte_rate;
			got.dsize = data_size;
			got.pbyte = payload_byte;
			got.last = last_payload;
			got.err = error_code;
			case (got.kind)
				whp_pkg::KIND_HEADER: hdr_seen++;
				whp_pkg::KIND_PAYLOAD: pay_seen++;
				default: err_seen++;
			endcase
			if (due_results.size() == 0) begin
				report("result with nothing expected", '0, got);
			end else begin
				want = due_results.pop_front();
				if (got !== want)
					report("result mismatch", want, got);
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int unsigned i = 0; i < DIR_ROWS; i++)
			drive_item(DIR_TAB[i].b, DIR_TAB[i].sof, DIR_TAB[i].chk, DIR_TAB[i].code);

		while (byte_count < DIR_ROWS + RAND_ITEMS)
			send_file();

		in_valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d bytes (%0d parsed) across directed and random WAV streams.",
			byte_count, parsed_count);
		$display("Checked %0d headers, %0d payload bytes, %0d tag errors; %0d failures.",
			hdr_seen, pay_seen, err_seen, fail_count);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("Timeout with %0d results still outstanding", due_results.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
